>>> rtl/psgrs_pkg.sv
// psgrs_pkg: shared types, constants and register map for the psg register shadow
`timescale 1ns / 1ps
package psgrs_pkg;

   // storage geometry
   localparam int StoreDepth = 32;
   localparam int StoreIdxW  = $clog2(StoreDepth);
   localparam int MapIdxW    = 5;

   // command codes
   localparam logic [2:0] CMD_WRITE       = 3'd0;
   localparam logic [2:0] CMD_READ        = 3'd1;
   localparam logic [2:0] CMD_CLEAR_MARKS = 3'd2;
   localparam logic [2:0] CMD_SET_MARKS   = 3'd3;
   localparam logic [2:0] CMD_CLEAR_DATA  = 3'd4;

   // map codes and mode detection
   localparam logic [7:0] NoMap       = 8'hFF;
   localparam logic [7:0] IdxFieldMsk = 8'h1F;
   localparam int         ShapeBit    = 7;
   localparam logic [7:0] ModeMask    = 8'hE0;
   localparam logic [7:0] ExpPattern  = 8'hA0;
   localparam logic [StoreIdxW-1:0] ModeIdx = StoreIdxW'(13);
   localparam logic [7:0] ShapeCodeReset = 8'hFF;

   // register map row: com_code, com_mask, exp_code, exp_mask
   localparam logic [31:0] RegMap [32] = '{
      32'h00FF00FF, 32'h010F01FF, 32'h02FF02FF, 32'h030F03FF,
      32'h04FF04FF, 32'h050F05FF, 32'h061F06FF, 32'h073F073F,
      32'h081F083F, 32'h091F093F, 32'h0A1F0A3F, 32'h0BFF0BFF,
      32'h0CFF0CFF, 32'h8DEF8DEF, 32'hFF00FF00, 32'hFF00FF00,
      32'hFF000EFF, 32'hFF000FFF, 32'hFF0010FF, 32'hFF0011FF,
      32'hFF00920F, 32'hFF00930F, 32'hFF00140F, 32'hFF00150F,
      32'hFF00160F, 32'hFF0017FF, 32'hFF0018FF, 32'hFF00FF00,
      32'hFF00FF00, 32'hFF008DEF, 32'hFF00FF00, 32'hFF00FF00
   };

   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] reg_num;
      logic [7:0] wr_data;
   } req_type;

   typedef struct packed {
      logic [7:0] rd_value;
      logic [7:0] raw_value;
      logic       is_changed;
      logic       is_known;
      logic       expanded_mode;
   } rsp_type;

   // result of a register map lookup
   typedef struct packed {
      logic                 known;
      logic                 shape;
      logic [StoreIdxW-1:0] idx;
      logic [7:0]           mask;
   } map_type;

   // expanded mode when the mode/bank byte carries the expanded pattern
   function automatic logic is_expanded(input logic [7:0] mode_byte);
      return (mode_byte & ModeMask) == ExpPattern;
   endfunction

endpackage

>>> rtl/psgrs_map.sv
// psgrs_map: register number to storage index, mask and shape flag decoder
`timescale 1ns / 1ps
module psgrs_map import psgrs_pkg::*; (
   input  logic [4:0] reg_num,
   input  logic       expanded,
   output map_type    lookup
);

   logic [31:0] row;
   logic [7:0]  code;
   logic [7:0]  mask;

   // pick the mode's column of the table
   always_comb begin
      row  = RegMap[reg_num];
      code = expanded ? row[15:8] : row[31:24];
      mask = expanded ? row[7:0] : row[23:16];
   end

   // unmapped codes and indexes past the store are unknown
   always_comb begin
      lookup.known = (code != NoMap) &&
                     ((MapIdxW + 1)'(code & IdxFieldMsk) < (MapIdxW + 1)'(StoreDepth));
      lookup.shape = code[ShapeBit];
      lookup.idx   = code[StoreIdxW-1:0];
      lookup.mask  = mask;
   end

endmodule

>>> rtl/psg_register_shadow_with_change_marks.sv
// psg_register_shadow_with_change_marks: shadow register file with change marks
// rsp_strobe is registered from an accepted start through req_valid_ff and then rsp_strobe_ff
// throughput: one transaction per cycle while busy is low, set by the single update/read pass on the flop store
// busy is high during reset and only in the first cycle after it; the receiver cannot stall
// reset clears all stored bytes and change marks and sets the unchanged shape code to ff
`timescale 1ns / 1ps
module psg_register_shadow_with_change_marks import psgrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req,
   output logic       rsp_strobe,
   output rsp_type    rsp,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                  busy_ff;
   logic                  req_valid_ff;
   req_type               req_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [7:0]            shape_code_ff;
   logic [7:0]            store_ff [StoreDepth];
   logic [7:0]            store_in [StoreDepth];
   logic [StoreDepth-1:0] marks_ff;
   logic [StoreDepth-1:0] marks_in;
   map_type               map_wr;
   map_type               map_rd;
   logic [7:0]            wr_masked;
   logic [7:0]            raw;
   logic                  mark;

   assign busy       = busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // control registers and config
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         shape_code_ff <= ShapeCodeReset;
      end else begin
         busy_ff       <= 1'b0;
         req_valid_ff  <= start && !busy_ff;
         rsp_strobe_ff <= req_valid_ff;
         if (csr_valid && csr_ready) begin
            shape_code_ff <= csr_data;
         end
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req;
      end
      rsp_ff <= rsp_in;
   end

   // lookup in the mode before the update
   psgrs_map u_map_wr (
      .reg_num  (req_ff.reg_num),
      .expanded (is_expanded(store_ff[ModeIdx])),
      .lookup   (map_wr)
   );

   // store update for the registered transaction
   always_comb begin
      store_in  = store_ff;
      marks_in  = marks_ff;
      wr_masked = req_ff.wr_data & map_wr.mask;
      if (req_valid_ff) begin
         unique case (req_ff.cmd)
            CMD_WRITE: begin
               if (map_wr.known) begin
                  if (map_wr.shape) begin
                     if (req_ff.wr_data != shape_code_ff) begin
                        // mode change wipes the data and marks everything
                        if (map_wr.idx == ModeIdx &&
                            ((store_ff[map_wr.idx] ^ wr_masked) & ModeMask) != 8'h00) begin
                           store_in = '{default: 8'h00};
                           marks_in = '1;
                        end
                        store_in[map_wr.idx] = wr_masked;
                        marks_in[map_wr.idx] = 1'b1;
                     end
                  end else if (store_ff[map_wr.idx] != wr_masked) begin
                     store_in[map_wr.idx] = wr_masked;
                     marks_in[map_wr.idx] = 1'b1;
                  end
               end
            end
            CMD_CLEAR_MARKS: marks_in = '0;
            CMD_SET_MARKS:   marks_in = '1;
            CMD_CLEAR_DATA:  store_in = '{default: 8'h00};
            default: begin
            end
         endcase
      end
   end

   // state store
   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '{default: 8'h00};
         marks_ff <= '0;
      end else begin
         store_ff <= store_in;
         marks_ff <= marks_in;
      end
   end

   // lookup in the mode after the update
   psgrs_map u_map_rd (
      .reg_num  (req_ff.reg_num),
      .expanded (is_expanded(store_in[ModeIdx])),
      .lookup   (map_rd)
   );

   // result from the updated state
   always_comb begin
      raw  = store_in[map_rd.idx];
      mark = marks_in[map_rd.idx];
      rsp_in.expanded_mode = is_expanded(store_in[ModeIdx]);
      rsp_in.is_known      = map_rd.known;
      if (map_rd.known) begin
         rsp_in.rd_value   = (map_rd.shape && !mark) ? shape_code_ff : raw;
         rsp_in.raw_value  = raw;
         rsp_in.is_changed = mark;
      end else begin
         rsp_in.rd_value   = 8'h00;
         rsp_in.raw_value  = 8'h00;
         rsp_in.is_changed = 1'b0;
      end
   end

`ifndef ASSERT_OFF
   // an accepted transaction is followed by a result strobe via req_valid_ff and rsp_strobe_ff
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_valid_ff))
      else $error("result strobe without a transaction");

   // unknown registers report all zero
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.is_known |->
         rsp.rd_value == 8'h00 && rsp.raw_value == 8'h00 && !rsp.is_changed)
      else $error("unknown register returned data");

   // read value differs from raw only for an unmarked known register
   a_rd_differs: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.rd_value != rsp.raw_value |-> rsp.is_known && !rsp.is_changed)
      else $error("substituted read on a marked or unknown register");

   // clearing the marks leaves the addressed register unmarked
   a_clear_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_ff.cmd == CMD_CLEAR_MARKS) |-> !rsp.is_changed)
      else $error("mark survived a clear marks command");
`endif

endmodule
